@@ src/irom_pkg.sv @@
// ----------------------------------------------------------------------------
// irom_pkg: shared types, constants and functions
// Holds the widths, the digit position codes, the ASCII symbols, and the
// per-digit length and character functions for the Roman numeral encoder.
// ----------------------------------------------------------------------------
package irom_pkg;

	localparam int VALUE_W = 12;
	localparam int BCD_W   = 16;
	localparam int CNT_W   = 4;

	// Digit positions, most significant first in the emit order.
	localparam logic [1:0] POS_UNIT = 2'd0;
	localparam logic [1:0] POS_TEN  = 2'd1;
	localparam logic [1:0] POS_HUND = 2'd2;
	localparam logic [1:0] POS_THOU = 2'd3;

	localparam logic [7:0] CH_I    = 8'h49;
	localparam logic [7:0] CH_V    = 8'h56;
	localparam logic [7:0] CH_X    = 8'h58;
	localparam logic [7:0] CH_L    = 8'h4C;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_M    = 8'h4D;
	localparam logic [7:0] CH_NONE = 8'h00;

	// Result of the binary to BCD converter, handed to the emitter.
	typedef struct packed {
		logic             done;
		logic [BCD_W-1:0] digits;
	} bcd_res_t;

	// Number of characters one decimal digit produces at a position.
	function automatic logic [2:0] digit_len(input logic [3:0] d, input logic [1:0] pos);
		logic [2:0] len;
		len = 3'd0;
		if (pos == POS_THOU) begin
			len = d[2:0];
		end else if (d == 4'd9 || d == 4'd4) begin
			len = 3'd2;
		end else if (d >= 4'd5 && d <= 4'd8) begin
			len = d[2:0] - 3'd4;
		end else if (d <= 4'd3) begin
			len = d[2:0];
		end
		return len;
	endfunction

	// Character number k of digit d at a position.
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic [1:0] k,
			input logic [1:0] pos);
		logic [7:0] one_c;
		logic [7:0] five_c;
		logic [7:0] ten_c;
		logic [7:0] ch;
		case (pos)
			POS_UNIT: begin
				one_c = CH_I; five_c = CH_V; ten_c = CH_X;
			end
			POS_TEN: begin
				one_c = CH_X; five_c = CH_L; ten_c = CH_C;
			end
			POS_HUND: begin
				one_c = CH_C; five_c = CH_D; ten_c = CH_M;
			end
			default: begin
				one_c = CH_M; five_c = CH_M; ten_c = CH_M;
			end
		endcase
		if (pos == POS_THOU) begin
			ch = one_c;
		end else if (d == 4'd9) begin
			ch = (k == 2'd0) ? one_c : ten_c;
		end else if (d == 4'd4) begin
			ch = (k == 2'd0) ? one_c : five_c;
		end else if (d >= 4'd5 && k == 2'd0) begin
			ch = five_c;
		end else begin
			ch = one_c;
		end
		return ch;
	endfunction

endpackage

@@ src/irom_bcd.sv @@
// ----------------------------------------------------------------------------
// irom_bcd: bit-serial binary to BCD converter
// Shift-and-add-3 conversion that takes one bit of the binary value per
// cycle until all 12 bits of the value have been shifted in.
// ----------------------------------------------------------------------------
module irom_bcd (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [irom_pkg::VALUE_W-1:0]  value,
	output irom_pkg::bcd_res_t            res
);
	import irom_pkg::*;

	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [BCD_W-1:0]   adj;

	// Each nibble of 5 or more gets 3 added before the next shift.
	always_comb begin
		for (int i = 0; i < BCD_W / 4; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

	assign res.done   = done_q;
	assign res.digits = bcd_q;

endmodule

@@ src/irom_emit.sv @@
// ----------------------------------------------------------------------------
// irom_emit: Roman numeral character sequencer
// Walks the BCD digits from thousands down, one character per cycle unless a
// stall holds the full output register, which keeps each result until taken.
// ----------------------------------------------------------------------------
module irom_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  irom_pkg::bcd_res_t  bcd,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [7:0]          out_char,
	output logic                last_char,
	output logic                range_error,
	output logic                finished
);
	import irom_pkg::*;

	logic             run_q;
	logic             err_q;
	logic [BCD_W-1:0] dig_q;
	logic [1:0]       pos_q;
	logic [1:0]       k_q;
	logic             ov_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             rerr_q;

	logic [3:0] cur_d;
	logic [2:0] len;
	logic       rest_zero;
	logic       can_load;
	logic       emit;
	logic       digit_end;
	logic       is_last;
	logic       bcd_err;

	assign cur_d     = dig_q[BCD_W-1 -: 4];
	assign len       = digit_len(cur_d, pos_q);
	assign rest_zero = (dig_q[BCD_W-5:0] == '0);
	assign can_load  = !ov_q || !out_stall;
	assign digit_end = ({1'b0, k_q} + 3'd1) == len;
	assign emit      = run_q && can_load && (err_q || len != 3'd0);
	assign is_last   = err_q || (digit_end && rest_zero);
	assign finished  = emit && is_last;

	// Zero, or a thousands digit of four, is out of range.
	assign bcd_err = (bcd.digits == '0) || (bcd.digits[BCD_W-1 -: 4] > 4'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			if (bcd.done) begin
				run_q <= 1'b1;
			end else if (finished) begin
				run_q <= 1'b0;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bcd.done) begin
			dig_q <= bcd.digits;
			err_q <= bcd_err;
			pos_q <= POS_THOU;
			k_q   <= '0;
		end else if (run_q && !err_q) begin
			if (len == 3'd0 || (emit && digit_end)) begin
				dig_q <= {dig_q[BCD_W-5:0], 4'd0};
				pos_q <= pos_q - 2'd1;
				k_q   <= '0;
			end else if (emit) begin
				k_q <= k_q + 2'd1;
			end
		end
		if (emit) begin
			char_q <= err_q ? CH_NONE : digit_char(cur_d, k_q, pos_q);
			last_q <= is_last;
			rerr_q <= err_q;
		end
	end

	assign out_valid   = ov_q;
	assign out_char    = char_q;
	assign last_char   = last_q;
	assign range_error = rerr_q;

endmodule

@@ src/integer_to_roman_encoder_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_top: binary value to Roman numeral characters
// Accepts a 12-bit value and streams its Roman numeral as ASCII characters.
// ----------------------------------------------------------------------------
// Each input transfer carries one value. The block answers with one output
// transfer per Roman numeral character, most significant symbol first, with
// last_char set on the final one. Values of 0 and from 4000 up give a single
// transfer with out_char 0, last_char 1 and range_error 1. One value is
// worked on at a time: after a value is taken, a bit-serial converter turns
// it into four BCD digits bit by bit and hands the digits to the sequencer,
// and the sequencer then issues one character per cycle, passing over each
// leading or inner digit that produces no character without issuing one,
// and waits while out_stall holds the output. in_stall drops again as soon
// as the final character is in the output register, so the next value can
// be taken while that character still waits to be accepted.
module integer_to_roman_encoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [irom_pkg::VALUE_W-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_char,
	output logic                          last_char,
	output logic                          range_error
);
	import irom_pkg::*;

	logic     busy_q;
	logic     accept;
	logic     finished;
	bcd_res_t bcd;

	// A transfer on the input side starts the converter right away.
	assign accept   = in_valid && !in_stall;
	assign in_stall = busy_q;

	// Busy from the input transfer until the final character is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (finished) begin
			busy_q <= 1'b0;
		end
	end

	irom_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.value  (value),
		.res    (bcd)
	);

	irom_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.bcd         (bcd),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_char    (out_char),
		.last_char   (last_char),
		.range_error (range_error),
		.finished    (finished)
	);

	// An error result always closes its numeral.
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> last_char)
		else $error("error result without last_char");

	// A valid numeral never carries the null character.
	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_error |-> out_char != CH_NONE)
		else $error("null character in a valid numeral");

	// The converter only finishes while a value is being worked on.
	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bcd.done |-> busy_q)
		else $error("conversion finished with no value in flight");

	// The final character is never registered while the block is idle.
	a_finish_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		finished |-> busy_q && !accept)
		else $error("final character issued outside a value");

endmodule

@@ bench/tb_integer_to_roman_encoder_top.sv @@
// ----------------------------------------------------------------------------
// tb_integer_to_roman_encoder_top: self-checking bench for the Roman encoder
// Feeds binary values through the input channel, predicts the characters of
// each numeral in a scoreboard, and checks every output transfer against it
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_integer_to_roman_encoder_top;
	import irom_pkg::*;

	// One expected or observed output transfer.
	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
		logic       err;
	} roman_char_t;

	// The scoreboard predicts the numeral of every value the block takes and
	// keeps its characters in order until the block sends them out.
	class roman_scoreboard;
		roman_char_t pending[$];
		logic [7:0]  numeral[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Appends the symbols of one decimal digit, given the one, five and
		// ten symbols of its position.
		function void add_digit(int unsigned d, logic [7:0] one_sym, logic [7:0] five_sym,
				logic [7:0] ten_sym);
			if (d == 9) begin
				numeral.push_back(one_sym);
				numeral.push_back(ten_sym);
			end else if (d == 4) begin
				numeral.push_back(one_sym);
				numeral.push_back(five_sym);
			end else begin
				if (d >= 5)
					numeral.push_back(five_sym);
				repeat (d % 5) numeral.push_back(one_sym);
			end
		endfunction

		function void note_value(logic [VALUE_W-1:0] v);
			int unsigned n;
			n = 32'(v);
			numeral.delete();
			if (n == 0 || n > 3999) begin
				pending.push_back(roman_char_t'{CH_NONE, 1'b1, 1'b1});
			end else begin
				repeat (n / 1000) numeral.push_back(CH_M);
				add_digit((n / 100) % 10, CH_C, CH_D, CH_M);
				add_digit((n / 10) % 10, CH_X, CH_L, CH_C);
				add_digit(n % 10, CH_I, CH_V, CH_X);
				foreach (numeral[i])
					pending.push_back(roman_char_t'{numeral[i], i == numeral.size() - 1, 1'b0});
			end
		endfunction

		function void check_char(roman_char_t got);
			roman_char_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR at %0t: unexpected transfer char=%h last=%b err=%b",
						$time, got.symbol, got.last, got.err);
			end else begin
				want = pending.pop_front();
				if (got.symbol !== want.symbol || got.last !== want.last || got.err !== want.err) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR at %0t: char %h/%h last %b/%b err %b/%b (expected/actual)",
							$time, want.symbol, got.symbol, want.last, got.last,
							want.err, got.err);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [VALUE_W-1:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         out_char;
	logic               last_char;
	logic               range_error;

	roman_scoreboard sb = new();

	// Handshake status seen at the latest rising edge, read by the drivers at
	// the following falling edge.
	bit          in_taken = 1'b0;
	int unsigned values_taken = 0;
	bit          draining = 1'b0;

	integer_to_roman_encoder_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last_char   (last_char),
		.range_error (range_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A stretch in the middle of the random part where neither side idles,
	// so that the block runs back to back at its own pace.
	function automatic bit calm_window();
		return values_taken >= 120 && values_taken < 150;
	endfunction

	// Length of one idle or busy stretch: mostly short, now and then long.
	function automatic int unsigned burst_len();
		int unsigned len;
		if ($urandom_range(0, 9) == 0)
			len = $urandom_range(8, 30);
		else
			len = $urandom_range(1, 3);
		return len;
	endfunction

	// Random values lean on valid numerals built digit by digit, so that every
	// digit shape shows up at every position, with zero and out-of-range
	// values mixed in.
	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned sel;
		int unsigned n;
		sel = $urandom_range(0, 99);
		if (sel < 6) begin
			n = 0;
		end else if (sel < 14) begin
			n = $urandom_range(4000, 4095);
		end else if (sel < 24) begin
			n = $urandom_range(1, 3999);
		end else begin
			do begin
				n = $urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
					+ $urandom_range(0, 9) * 10 + $urandom_range(0, 9);
			end while (n == 0);
		end
		return VALUE_W'(n);
	endfunction

	// Sampling happens at the rising edge, before the block's own updates land.
	// Every accepted value goes to the predictor, and every accepted character
	// is checked against the oldest expectation.
	always @(posedge clk) begin
		in_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_value(value);
				values_taken++;
				in_taken = 1'b1;
			end
			if (out_valid && !out_stall)
				sb.check_char(roman_char_t'{out_char, last_char, range_error});
		end
	end

	// Offers one value, after an optional idle gap, and holds it until the
	// block takes it. Valid is only lowered when a gap follows, so a value
	// offered right after a transfer keeps valid high without a glitch.
	task automatic offer_value(input logic [VALUE_W-1:0] v);
		int unsigned gap;
		gap = 0;
		if (!calm_window() && $urandom_range(0, 99) >= 55)
			gap = burst_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			value    <= VALUE_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(negedge clk); while (!in_taken);
	endtask

	// Sender: reset, the directed values, then the random ones, then the drain.
	initial begin
		int unsigned directed_values[24] = '{
			0, 1, 4095, 4000, 3999, 3888, 4, 9, 5, 8, 40, 90,
			400, 900, 1000, 2000, 3000, 3949, 444, 999, 1994, 2730, 1365, 500
		};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: both range errors, the extremes, every subtractive
		// pair, bare five-symbols, full runs of one-symbols at each position,
		// the longest numeral, and alternating bit patterns on the value.
		foreach (directed_values[i])
			offer_value(VALUE_W'(directed_values[i]));

		for (int i = 0; i < 146; i++)
			offer_value(pick_value());
		in_valid <= 1'b0;
		draining = 1'b1;

		// Wait for every predicted character, then give the block time to
		// show any character that should not be there.
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (64) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("PASS integer_to_roman_encoder_top");
		else
			$display("FAIL integer_to_roman_encoder_top");
		$finish;
	end

	// Receiver: random stall stretches, a calm stretch, and one long hold-off
	// once forty values have gone in. During the hold-off the sender keeps
	// offering values, so the block fills and raises in_stall on its input.
	initial begin
		int unsigned run_left = 0;
		int unsigned hold_left = 0;
		bit          stall_now = 1'b0;
		bit          hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && values_taken >= 40) begin
				hold_done = 1'b1;
				hold_left = 200;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (draining || calm_window()) begin
				out_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					stall_now = $urandom_range(0, 99) < 35;
					run_left  = burst_len();
				end
				run_left--;
				out_stall <= stall_now;
			end
		end
	end

	// Watchdog: far beyond the slowest correct run, where every character
	// waits out a long stall and every value follows a long gap.
	initial begin
		#5000000;
		$display("FAIL integer_to_roman_encoder_top");
		$finish;
	end

endmodule
